### rtl/core/tkss_pkg.sv
// shared constants for the top-k score selection core
package tkss_pkg;

  localparam int DEF_MAX_K         = 16;
  localparam int DEF_GALLERY_DEPTH = 65536;
  localparam int DEF_SCORE_BITS    = 16;

  localparam int SCORE_W     = 16;
  localparam int INDEX_W     = 16;
  localparam int RANK_W      = 4;
  localparam int TOP_COUNT_W = 5;

  localparam logic [TOP_COUNT_W-1:0] TOP_COUNT_RST = TOP_COUNT_W'(5);

endpackage

### rtl/core/top_k_score_select_core.sv
// top level of the streaming top-k score selection core
//
// usage:
//   scores arrive as beats on the in channel (in_valid_i / in_ready_o), one per
//   gallery entry, numbered from 0 within a query; last_score_i marks the final
//   beat. the best top_count pairs (clamped to 1..MAX_K) are kept in a sorted
//   chain of cells, one insertion per cycle, so one score beat per cycle.
//   on the last beat the sorted list is copied into a result chain and the
//   keep chain clears; results leave on the out channel best first, one beat
//   per cycle, starting the cycle after the last beat, with last_match_o on
//   the final one. a query that ends with no kept pair gives no results.
//   score beats keep flowing while results drain; only a last beat waits,
//   while results of the previous query are still queued, unless the final
//   one leaves in the same cycle.
//   an out_ready_i stall holds the head result; a last beat arriving then
//   stalls the in channel until the queued results have left.
//   cfg_we_i / cfg_wdata_i write top_count; the user must write it only while
//   the core is idle (not enforced). reset: top_count is 5, no pairs held,
//   arrival count zero, no results. scores past the gallery depth are dropped.
module top_k_score_select_core #(
  parameter int MAX_K         = tkss_pkg::DEF_MAX_K,
  parameter int GALLERY_DEPTH = tkss_pkg::DEF_GALLERY_DEPTH,
  parameter int SCORE_BITS    = tkss_pkg::DEF_SCORE_BITS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tkss_pkg::TOP_COUNT_W-1:0]    cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [tkss_pkg::SCORE_W-1:0] score_i,
  input  logic                                last_score_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic [tkss_pkg::RANK_W-1:0]         rank_o,
  output logic [tkss_pkg::INDEX_W-1:0]        match_index_o,
  output logic signed [tkss_pkg::SCORE_W-1:0] match_score_o,
  output logic                                last_match_o
);

  import tkss_pkg::*;

  localparam int CW    = $clog2(MAX_K + 1);
  localparam int IW    = (MAX_K > 1) ? $clog2(MAX_K) : 1;
  localparam int POS_W = $clog2(GALLERY_DEPTH);
  localparam int ARR_W = POS_W + 1;

  logic [TOP_COUNT_W-1:0] top_count_q;
  logic [CW-1:0]          k_eff;
  logic [CW-1:0]          kept_cnt_q, kept_cnt_d;
  logic [ARR_W-1:0]       arr_cnt_q, arr_cnt_d;
  logic [CW-1:0]          out_cnt_q, out_cnt_d;
  logic [IW-1:0]          rank_q, rank_d;

  logic                  in_acc, in_range, add_mode, lowest_gt, ins;
  logic                  drain_free, pop, load;
  logic [CW-1:0]         emit_cnt;
  logic [SCORE_BITS-1:0] new_score;
  logic [POS_W-1:0]      new_pos;

  logic [MAX_K-1:0]      above_vec, gt_vec;
  logic [SCORE_BITS-1:0] keep_score [MAX_K];
  logic [POS_W-1:0]      keep_pos   [MAX_K];
  logic [SCORE_BITS-1:0] keep_score_nx [MAX_K];
  logic [POS_W-1:0]      keep_pos_nx   [MAX_K];
  logic [SCORE_BITS-1:0] drn_score [MAX_K];
  logic [POS_W-1:0]      drn_pos   [MAX_K];

  // config register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      top_count_q <= TOP_COUNT_RST;
    end else if (cfg_we_i) begin
      top_count_q <= cfg_wdata_i;
    end
  end

  always_comb begin
    if (top_count_q == '0) begin
      k_eff = CW'(1);
    end else if (int'(top_count_q) > MAX_K) begin
      k_eff = CW'(MAX_K);
    end else begin
      k_eff = CW'(top_count_q);
    end
  end

  assign new_score = SCORE_BITS'($unsigned(score_i));
  assign new_pos   = POS_W'(arr_cnt_q);

  assign drain_free = (out_cnt_q == '0) || ((out_cnt_q == CW'(1)) && out_ready_i);
  assign in_ready_o = !last_score_i || drain_free;
  assign in_acc     = in_valid_i && in_ready_o;
  assign in_range   = arr_cnt_q < ARR_W'(GALLERY_DEPTH);
  assign add_mode   = kept_cnt_q < k_eff;
  assign lowest_gt  = gt_vec[IW'(kept_cnt_q - CW'(1))];
  assign ins        = in_acc && in_range && (add_mode || lowest_gt);

  // keep chain, sorted best first
  for (genvar i = 0; i < MAX_K; i++) begin : g_keep
    logic                  prev_above;
    logic [SCORE_BITS-1:0] prev_score;
    logic [POS_W-1:0]      prev_pos;

    if (i == 0) begin : g_head
      assign prev_above = 1'b0;
      assign prev_score = new_score;
      assign prev_pos   = new_pos;
    end else begin : g_body
      assign prev_above = above_vec[i-1];
      assign prev_score = keep_score[i-1];
      assign prev_pos   = keep_pos[i-1];
    end

    tkss_keep_cell #(
      .SCORE_BITS(SCORE_BITS),
      .POS_W     (POS_W)
    ) u_keep (
      .clk_i       (clk_i),
      .ins_i       (ins),
      .valid_i     (CW'(i) < kept_cnt_q),
      .new_score_i (new_score),
      .new_pos_i   (new_pos),
      .prev_above_i(prev_above),
      .prev_score_i(prev_score),
      .prev_pos_i  (prev_pos),
      .above_o     (above_vec[i]),
      .gt_o        (gt_vec[i]),
      .score_o     (keep_score[i]),
      .pos_o       (keep_pos[i]),
      .score_nx_o  (keep_score_nx[i]),
      .pos_nx_o    (keep_pos_nx[i])
    );
  end

  always_comb begin
    kept_cnt_d = kept_cnt_q;
    if (ins && add_mode) begin
      kept_cnt_d = kept_cnt_q + CW'(1);
    end
    arr_cnt_d = arr_cnt_q;
    if (in_acc && in_range) begin
      arr_cnt_d = arr_cnt_q + ARR_W'(1);
    end
  end

  assign emit_cnt = (kept_cnt_d < k_eff) ? kept_cnt_d : k_eff;
  assign load     = in_acc && last_score_i;
  assign pop      = out_valid_o && out_ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kept_cnt_q <= '0;
      arr_cnt_q  <= '0;
    end else if (load) begin
      kept_cnt_q <= '0;
      arr_cnt_q  <= '0;
    end else begin
      kept_cnt_q <= kept_cnt_d;
      arr_cnt_q  <= arr_cnt_d;
    end
  end

  // result chain, head is cell 0
  for (genvar i = 0; i < MAX_K; i++) begin : g_drain
    logic [SCORE_BITS-1:0] next_score;
    logic [POS_W-1:0]      next_pos;

    if (i == MAX_K - 1) begin : g_tail
      assign next_score = drn_score[i];
      assign next_pos   = drn_pos[i];
    end else begin : g_body
      assign next_score = drn_score[i+1];
      assign next_pos   = drn_pos[i+1];
    end

    tkss_drain_cell #(
      .SCORE_BITS(SCORE_BITS),
      .POS_W     (POS_W)
    ) u_drain (
      .clk_i       (clk_i),
      .load_i      (load),
      .shift_i     (pop),
      .load_score_i(keep_score_nx[i]),
      .load_pos_i  (keep_pos_nx[i]),
      .next_score_i(next_score),
      .next_pos_i  (next_pos),
      .score_o     (drn_score[i]),
      .pos_o       (drn_pos[i])
    );
  end

  always_comb begin
    out_cnt_d = out_cnt_q;
    rank_d    = rank_q;
    if (load) begin
      out_cnt_d = emit_cnt;
      rank_d    = '0;
    end else if (pop) begin
      out_cnt_d = out_cnt_q - CW'(1);
      rank_d    = rank_q + IW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_cnt_q <= '0;
      rank_q    <= '0;
    end else begin
      out_cnt_q <= out_cnt_d;
      rank_q    <= rank_d;
    end
  end

  assign out_valid_o   = out_cnt_q != '0;
  assign last_match_o  = out_cnt_q == CW'(1);
  assign rank_o        = RANK_W'(rank_q);
  assign match_index_o = INDEX_W'(drn_pos[0]);
  assign match_score_o = $signed(SCORE_W'(drn_score[0]));

  a_kept_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    int'(kept_cnt_q) <= MAX_K && int'(out_cnt_q) <= MAX_K)
    else $error("pair count above chain length");

  a_clear_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && last_score_i) |=> (kept_cnt_q == '0 && arr_cnt_q == '0))
    else $error("keep chain not cleared after last beat");

  a_results_continue: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_match_o) |=> out_valid_o)
    else $error("result run broken before its last beat");

  a_descending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_ready_i && !last_match_o) |=>
      !($signed(drn_score[0]) > $signed($past(drn_score[0]))))
    else $error("results not in descending score order");

endmodule

### rtl/core/tkss_keep_cell.sv
// one slot of the sorted keep chain, shifts down on insertion
module tkss_keep_cell #(
  parameter int SCORE_BITS = 16,
  parameter int POS_W      = 16
) (
  input  logic                  clk_i,
  input  logic                  ins_i,
  input  logic                  valid_i,
  input  logic [SCORE_BITS-1:0] new_score_i,
  input  logic [POS_W-1:0]      new_pos_i,
  input  logic                  prev_above_i,
  input  logic [SCORE_BITS-1:0] prev_score_i,
  input  logic [POS_W-1:0]      prev_pos_i,
  output logic                  above_o,
  output logic                  gt_o,
  output logic [SCORE_BITS-1:0] score_o,
  output logic [POS_W-1:0]      pos_o,
  output logic [SCORE_BITS-1:0] score_nx_o,
  output logic [POS_W-1:0]      pos_nx_o
);

  logic [SCORE_BITS-1:0] score_q, score_d;
  logic [POS_W-1:0]      pos_q, pos_d;

  // new pair always has the highest position, so ties rank it above
  assign above_o = !valid_i || ($signed(new_score_i) >= $signed(score_q));
  assign gt_o    = $signed(new_score_i) > $signed(score_q);

  always_comb begin
    score_d = score_q;
    pos_d   = pos_q;
    if (ins_i && prev_above_i) begin
      score_d = prev_score_i;
      pos_d   = prev_pos_i;
    end else if (ins_i && above_o) begin
      score_d = new_score_i;
      pos_d   = new_pos_i;
    end
  end

  always_ff @(posedge clk_i) begin
    score_q <= score_d;
    pos_q   <= pos_d;
  end

  assign score_o    = score_q;
  assign pos_o      = pos_q;
  assign score_nx_o = score_d;
  assign pos_nx_o   = pos_d;

endmodule

### rtl/core/tkss_drain_cell.sv
// one slot of the result chain, loaded in parallel and shifted toward the head
module tkss_drain_cell #(
  parameter int SCORE_BITS = 16,
  parameter int POS_W      = 16
) (
  input  logic                  clk_i,
  input  logic                  load_i,
  input  logic                  shift_i,
  input  logic [SCORE_BITS-1:0] load_score_i,
  input  logic [POS_W-1:0]      load_pos_i,
  input  logic [SCORE_BITS-1:0] next_score_i,
  input  logic [POS_W-1:0]      next_pos_i,
  output logic [SCORE_BITS-1:0] score_o,
  output logic [POS_W-1:0]      pos_o
);

  logic [SCORE_BITS-1:0] score_q, score_d;
  logic [POS_W-1:0]      pos_q, pos_d;

  always_comb begin
    score_d = score_q;
    pos_d   = pos_q;
    if (load_i) begin
      score_d = load_score_i;
      pos_d   = load_pos_i;
    end else if (shift_i) begin
      score_d = next_score_i;
      pos_d   = next_pos_i;
    end
  end

  always_ff @(posedge clk_i) begin
    score_q <= score_d;
    pos_q   <= pos_d;
  end

  assign score_o = score_q;
  assign pos_o   = pos_q;

endmodule
